### rtl/rbfi_pkg.sv
package rbfi_pkg;

	localparam logic [1:0] STATUS_DONE = 2'd0;
	localparam logic [1:0] STATUS_OFF_GRID = 2'd1;
	localparam logic [1:0] STATUS_NO_INJECT = 2'd2;

	localparam logic [2:0] REG_DENSITY = 3'd0;
	localparam logic [2:0] REG_FORCE = 3'd1;
	localparam logic [2:0] REG_RADIUS = 3'd2;
	localparam logic [2:0] REG_WIDTH = 3'd3;
	localparam logic [2:0] REG_HEIGHT = 3'd4;

	localparam logic [0:0] CMD_INJECT = 1'b0;
	localparam logic [0:0] CMD_READ = 1'b1;

	localparam logic [16:0] RADIUS_ONE = 17'h10000;

	// clamped brush settings seen by the core
	typedef struct packed {
		logic [15:0] density;
		logic [15:0] force_gain;
		logic [16:0] radius;
		logic [6:0] width;
		logic [6:0] height;
	} rbfi_cfg_t;

	typedef struct packed {
		logic cmd;
		logic [5:0] column;
		logic [5:0] row;
		logic [15:0] delta_x;
		logic [15:0] delta_y;
	} rbfi_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [31:0] density;
		logic [31:0] vel_x;
		logic [31:0] vel_y;
	} rbfi_res_t;

endpackage

### rtl/rbfi_ram.sv
module rbfi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

### rtl/rbfi_core.sv
module rbfi_core #(
	parameter int GRID_COLUMNS = 64,
	parameter int GRID_ROWS = 64
) (
	input logic clk,
	input logic arst_n,
	input rbfi_pkg::rbfi_cfg_t cfg,
	input rbfi_pkg::rbfi_req_t req,
	input logic start,
	output logic idle,
	output logic res_valid,
	output rbfi_pkg::rbfi_res_t res,
	input logic res_take
);
	localparam int CELLS = GRID_COLUMNS * GRID_ROWS;
	localparam int AW = $clog2(CELLS);
	localparam logic [16:0] RADIUS_ONE_C = rbfi_pkg::RADIUS_ONE;

	typedef enum logic [4:0] {
		ST_CLR, ST_IDLE, ST_RD1, ST_RD2, ST_RW, ST_RH, ST_T, ST_TT, ST_BOX,
		ST_A, ST_B, ST_AA, ST_BB, ST_Q, ST_IN, ST_SQ, ST_D0, ST_DV,
		ST_DEN, ST_VX1, ST_VX2, ST_VY1, ST_VY2, ST_WR, ST_DONE
	} state_t;

	state_t state_q;
	logic [AW-1:0] clr_q;
	logic [6:0] cx_q, cy_q, x_q, y_q, x0_q, x1_q, y1_q, w_q, h_q, rx_q, ry_q;
	logic [16:0] r_q;
	logic [15:0] den_q, frc_q, magx_q, magy_q;
	logic negx_q, negy_q, do_den_q, do_vel_q;
	logic [22:0] rw_q;
	logic [30:0] t_q;
	logic [61:0] tt_q;
	logic [13:0] a_q, b_q;
	logic [28:0] q_q;
	logic [61:0] v_q;
	logic [32:0] rem_q;
	logic [30:0] root_q;
	logic [4:0] sq_cnt_q;
	logic [30:0] drem_q;
	logic [16:0] quot_q;
	logic [3:0] dv_cnt_q;
	logic [31:0] dn_new_q, vx_new_q;
	logic [63:0] p_q;
	rbfi_pkg::rbfi_res_t res_q;

	logic [31:0] mul_a, mul_b;
	logic [AW-1:0] cell_addr, ram_addr;
	logic we_den, we_vel;
	logic [31:0] wd_den, wd_vx, wd_vy, rd_den, rd_vx, rd_vy;
	logic [6:0] dxabs, dyabs;
	logic [16:0] fall;
	logic last_cell;
	logic [34:0] sq_sh, sq_trial, sq_diff;
	logic sq_ge;
	logic [31:0] dv_sh;
	logic dv_ge;
	logic [32:0] den_sum;
	logic [31:0] den_sat, vx_sat, vy_sat;
	logic [6:0] wm, hm;
	logic [6:0] x0_c, x1_c, y0_c, y1_c;
	logic off_c, do_den_c, do_vel_c;
	logic [15:0] dx_mag, dy_mag;

	function automatic logic [31:0] vel_add(input logic [31:0] old, input logic [24:0] term,
			input logic neg);
		logic signed [33:0] s;
		s = $signed({{2{old[31]}}, old}) + (neg ? -$signed({9'b0, term}) : $signed({9'b0, term}));
		if (s > 34'sh07FFFFFFF) begin
			return 32'h7FFFFFFF;
		end else if (s < -34'sh080000000) begin
			return 32'h80000000;
		end
		return s[31:0];
	endfunction

	assign cell_addr = AW'(32'(y_q) * GRID_COLUMNS + 32'(x_q));
	assign ram_addr = (state_q == ST_CLR) ? clr_q : cell_addr;
	assign dxabs = (x_q > cx_q) ? x_q - cx_q : cx_q - x_q;
	assign dyabs = (y_q > cy_q) ? y_q - cy_q : cy_q - y_q;
	assign fall = RADIUS_ONE_C - quot_q;
	assign last_cell = (x_q == x1_q) && (y_q == y1_q);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_RW: begin mul_a = 32'(r_q); mul_b = 32'(w_q); end
			ST_RH: begin mul_a = 32'(r_q); mul_b = 32'(h_q); end
			ST_T: begin mul_a = 32'(rw_q); mul_b = 32'(h_q); end
			ST_TT: begin mul_a = 32'(p_q[30:0]); mul_b = 32'(p_q[30:0]); end
			ST_A: begin mul_a = 32'(dxabs); mul_b = 32'(h_q); end
			ST_B: begin mul_a = 32'(dyabs); mul_b = 32'(w_q); end
			ST_AA: begin mul_a = 32'(a_q); mul_b = 32'(a_q); end
			ST_BB: begin mul_a = 32'(b_q); mul_b = 32'(b_q); end
			ST_DEN: begin mul_a = 32'(den_q); mul_b = 32'(fall); end
			ST_VX1: begin mul_a = 32'(magx_q); mul_b = 32'(frc_q); end
			ST_VX2: begin mul_a = p_q[31:0]; mul_b = 32'(fall); end
			ST_VY1: begin mul_a = 32'(magy_q); mul_b = 32'(frc_q); end
			ST_VY2: begin mul_a = p_q[31:0]; mul_b = 32'(fall); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign sq_sh = {rem_q, v_q[61:60]};
	assign sq_trial = {2'b0, root_q, 2'b01};
	assign sq_ge = sq_sh >= sq_trial;
	assign sq_diff = sq_sh - sq_trial;
	assign dv_sh = {drem_q, 1'b0};
	assign dv_ge = dv_sh >= {1'b0, t_q};

	assign den_sum = {1'b0, rd_den} + 33'(p_q[31:8]);
	assign den_sat = den_sum[32] ? 32'hFFFFFFFF : den_sum[31:0];
	assign vx_sat = vel_add(rd_vx, p_q[47:23], negx_q);
	assign vy_sat = vel_add(rd_vy, p_q[47:23], negy_q);

	assign wm = w_q - 7'd1 - cx_q;
	assign hm = h_q - 7'd1 - cy_q;
	assign x0_c = (cx_q < rx_q) ? 7'd0 : cx_q - rx_q;
	assign x1_c = (wm < rx_q) ? w_q - 7'd1 : cx_q + rx_q;
	assign y0_c = (cy_q < ry_q) ? 7'd0 : cy_q - ry_q;
	assign y1_c = (hm < ry_q) ? h_q - 7'd1 : cy_q + ry_q;

	assign off_c = ({1'b0, req.column} >= cfg.width) || ({1'b0, req.row} >= cfg.height);
	assign do_den_c = cfg.density != '0;
	assign do_vel_c = (cfg.force_gain != '0) && ((req.delta_x != '0) || (req.delta_y != '0));
	assign dx_mag = req.delta_x[15] ? 16'(-req.delta_x) : req.delta_x;
	assign dy_mag = req.delta_y[15] ? 16'(-req.delta_y) : req.delta_y;

	assign we_den = (state_q == ST_CLR) || ((state_q == ST_WR) && do_den_q);
	assign we_vel = (state_q == ST_CLR) || ((state_q == ST_WR) && do_vel_q);
	assign wd_den = (state_q == ST_CLR) ? '0 : dn_new_q;
	assign wd_vx = (state_q == ST_CLR) ? '0 : vx_new_q;
	assign wd_vy = (state_q == ST_CLR) ? '0 : vy_sat;

	rbfi_ram #(.WIDTH(32), .DEPTH(CELLS)) u_den (
		.clk(clk), .we(we_den), .addr(ram_addr), .wdata(wd_den), .rdata(rd_den));
	rbfi_ram #(.WIDTH(32), .DEPTH(CELLS)) u_vx (
		.clk(clk), .we(we_vel), .addr(ram_addr), .wdata(wd_vx), .rdata(rd_vx));
	rbfi_ram #(.WIDTH(32), .DEPTH(CELLS)) u_vy (
		.clk(clk), .we(we_vel), .addr(ram_addr), .wdata(wd_vy), .rdata(rd_vy));

	assign idle = state_q == ST_IDLE;
	assign res_valid = state_q == ST_DONE;
	assign res = res_q;

	always_ff @(posedge clk) begin
		p_q <= {32'b0, mul_a} * {32'b0, mul_b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						cx_q <= {1'b0, req.column};
						cy_q <= {1'b0, req.row};
						x_q <= {1'b0, req.column};
						y_q <= {1'b0, req.row};
						w_q <= cfg.width;
						h_q <= cfg.height;
						r_q <= cfg.radius;
						den_q <= cfg.density;
						frc_q <= cfg.force_gain;
						magx_q <= dx_mag;
						magy_q <= dy_mag;
						negx_q <= req.delta_x[15];
						negy_q <= req.delta_y[15];
						do_den_q <= do_den_c;
						do_vel_q <= do_vel_c;
						res_q.density <= '0;
						res_q.vel_x <= '0;
						res_q.vel_y <= '0;
						if (off_c) begin
							res_q.status <= rbfi_pkg::STATUS_OFF_GRID;
							state_q <= ST_DONE;
						end else if (req.cmd == rbfi_pkg::CMD_READ) begin
							res_q.status <= rbfi_pkg::STATUS_DONE;
							state_q <= ST_RD1;
						end else if ((!do_den_c && !do_vel_c) || cfg.radius == '0) begin
							res_q.status <= rbfi_pkg::STATUS_NO_INJECT;
							state_q <= ST_DONE;
						end else begin
							res_q.status <= rbfi_pkg::STATUS_DONE;
							state_q <= ST_RW;
						end
					end
				end
				ST_RD1: state_q <= ST_RD2;
				ST_RD2: begin
					res_q.status <= rbfi_pkg::STATUS_DONE;
					res_q.density <= rd_den;
					res_q.vel_x <= rd_vx;
					res_q.vel_y <= rd_vy;
					state_q <= ST_DONE;
				end
				ST_RW: state_q <= ST_RH;
				ST_RH: begin
					rw_q <= p_q[22:0];
					state_q <= ST_T;
				end
				ST_T: begin
					rx_q <= rw_q[22:16];
					ry_q <= p_q[22:16];
					state_q <= ST_TT;
				end
				ST_TT: begin
					t_q <= p_q[30:0];
					state_q <= ST_BOX;
				end
				ST_BOX: begin
					tt_q <= p_q[61:0];
					x0_q <= x0_c;
					x1_q <= x1_c;
					y1_q <= y1_c;
					x_q <= x0_c;
					y_q <= y0_c;
					state_q <= ST_A;
				end
				ST_A: state_q <= ST_B;
				ST_B: begin
					a_q <= p_q[13:0];
					state_q <= ST_AA;
				end
				ST_AA: begin
					b_q <= p_q[13:0];
					state_q <= ST_BB;
				end
				ST_BB: begin
					q_q <= p_q[28:0];
					state_q <= ST_Q;
				end
				ST_Q: begin
					q_q <= q_q + p_q[28:0];
					state_q <= ST_IN;
				end
				ST_IN: begin
					if ({1'b0, q_q, 32'b0} > tt_q) begin
						// outside the circle
						if (last_cell) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_A;
							if (x_q == x1_q) begin
								x_q <= x0_q;
								y_q <= y_q + 7'd1;
							end else begin
								x_q <= x_q + 7'd1;
							end
						end
					end else begin
						v_q <= {1'b0, q_q, 32'b0};
						rem_q <= '0;
						root_q <= '0;
						sq_cnt_q <= 5'd30;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					rem_q <= sq_ge ? sq_diff[32:0] : sq_sh[32:0];
					root_q <= {root_q[29:0], sq_ge};
					v_q <= {v_q[59:0], 2'b00};
					sq_cnt_q <= sq_cnt_q - 5'd1;
					if (sq_cnt_q == '0) begin
						state_q <= ST_D0;
					end
				end
				ST_D0: begin
					// root never exceeds t inside the circle, so quotient fits 17 bits
					quot_q <= 17'(root_q >= t_q);
					drem_q <= (root_q >= t_q) ? root_q - t_q : root_q;
					dv_cnt_q <= 4'd15;
					state_q <= ST_DV;
				end
				ST_DV: begin
					drem_q <= dv_ge ? 31'(dv_sh - {1'b0, t_q}) : dv_sh[30:0];
					quot_q <= {quot_q[15:0], dv_ge};
					dv_cnt_q <= dv_cnt_q - 4'd1;
					if (dv_cnt_q == '0) begin
						state_q <= ST_DEN;
					end
				end
				ST_DEN: state_q <= ST_VX1;
				ST_VX1: begin
					dn_new_q <= den_sat;
					state_q <= ST_VX2;
				end
				ST_VX2: state_q <= ST_VY1;
				ST_VY1: begin
					vx_new_q <= vx_sat;
					state_q <= ST_VY2;
				end
				ST_VY2: state_q <= ST_WR;
				ST_WR: begin
					if (last_cell) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_A;
						if (x_q == x1_q) begin
							x_q <= x0_q;
							y_q <= y_q + 7'd1;
						end else begin
							x_q <= x_q + 7'd1;
						end
					end
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### rtl/radial_brush_field_injector.sv
// Radial brush injector over density and velocity grids.
// Input channel (in_valid/in_ready): command, column, row, delta_x, delta_y.
// A read word returns one cell; an inject word adds a circular brush with
// linear falloff to every cell of its clipped bounding box inside the circle.
// Output channel (out_valid/out_ready): status and the three cell values.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready.
// One word is processed at a time; in_ready is low until its result is in
// the output register, and rises together with out_valid. An off-grid or
// empty word goes straight to the core's done state; a read first reads the
// three grids. An inject first sets up the box and threshold with the shared
// multiplier, then per box cell tests the cell against the circle; a cell
// inside it walks a 31-step square root and a 17-step divider one step per
// cycle, then a read-modify-write. The result then goes to the output register.
// After reset all GRID_COLUMNS*GRID_ROWS grid cells are zeroed one cell per
// cycle, with in_ready low. A stalled receiver holds the result in the output
// register and the core waits with the next result.
module radial_brush_field_injector #(
	parameter int GRID_COLUMNS = 64,
	parameter int GRID_ROWS = 64
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic command,
	input logic [5:0] column,
	input logic [5:0] row,
	input logic signed [15:0] delta_x,
	input logic signed [15:0] delta_y,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] status,
	output logic [31:0] density_value,
	output logic signed [31:0] velocity_x_value,
	output logic signed [31:0] velocity_y_value,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [16:0] cfg_data
);
	localparam int WMAX = GRID_COLUMNS > 127 ? 127 : GRID_COLUMNS;
	localparam int HMAX = GRID_ROWS > 127 ? 127 : GRID_ROWS;

	logic [15:0] density_q, force_q;
	logic [16:0] radius_q;
	logic [6:0] width_q, height_q;
	rbfi_pkg::rbfi_cfg_t cfg;
	rbfi_pkg::rbfi_req_t req;
	rbfi_pkg::rbfi_res_t core_res, out_q;
	logic core_idle, core_valid, take, out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			density_q <= 16'd256;
			force_q <= 16'd256;
			radius_q <= 17'd6554;
			width_q <= 7'd64;
			height_q <= 7'd64;
		end else if (cfg_valid) begin
			case (cfg_index)
				rbfi_pkg::REG_DENSITY: density_q <= cfg_data[15:0];
				rbfi_pkg::REG_FORCE: force_q <= cfg_data[15:0];
				rbfi_pkg::REG_RADIUS: radius_q <= cfg_data;
				rbfi_pkg::REG_WIDTH: width_q <= cfg_data[6:0];
				rbfi_pkg::REG_HEIGHT: height_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.density = density_q;
		cfg.force_gain = force_q;
		cfg.radius = (radius_q > rbfi_pkg::RADIUS_ONE) ? rbfi_pkg::RADIUS_ONE : radius_q;
		cfg.width = (width_q == '0) ? 7'd1 : (width_q > 7'(WMAX)) ? 7'(WMAX) : width_q;
		cfg.height = (height_q == '0) ? 7'd1 : (height_q > 7'(HMAX)) ? 7'(HMAX) : height_q;
		req.cmd = command;
		req.column = column;
		req.row = row;
		req.delta_x = delta_x;
		req.delta_y = delta_y;
	end

	assign in_ready = core_idle;
	assign take = core_valid && (!out_valid_q || out_ready);

	rbfi_core #(.GRID_COLUMNS(GRID_COLUMNS), .GRID_ROWS(GRID_ROWS)) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.req(req),
		.start(in_valid),
		.idle(core_idle),
		.res_valid(core_valid),
		.res(core_res),
		.res_take(take)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= core_res;
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_q.status;
	assign density_value = out_q.density;
	assign velocity_x_value = $signed(out_q.vel_x);
	assign velocity_y_value = $signed(out_q.vel_y);

`ifndef NO_ASSERTIONS
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in flight");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == rbfi_pkg::STATUS_DONE || status == rbfi_pkg::STATUS_OFF_GRID ||
			status == rbfi_pkg::STATUS_NO_INJECT))
		else $error("bad status code");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != rbfi_pkg::STATUS_DONE |->
			density_value == '0 && velocity_x_value == '0 && velocity_y_value == '0)
		else $error("error result carries values");
`endif
endmodule
